>>> hdl/matrix_inverse_3x3_unit_assert.svh
// ============================================================================
// matrix_inverse_3x3_unit_assert.svh
// Assertion macros used by mi3_checker, the port checks of the 3x3 inverse unit.
// ============================================================================
`ifndef MATRIX_INVERSE_3X3_UNIT_ASSERT_SVH
`define MATRIX_INVERSE_3X3_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is high
`define MI3_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also runs during reset
`define MI3_ASSERT_NR(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

>>> hdl/mi3_pkg.sv
// ============================================================================
// mi3_pkg
// Shared constants and cofactor index tables for the 3x3 inverse unit.
// ============================================================================
`default_nettype none

package mi3_pkg;

   // defaults for the top-level parameters
   localparam int ENTRY_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;

   // result format: signed Q16.16
   localparam int OUT_BITS = 32;
   localparam int OUT_FRAC = 16;

   // quotient bits kept by the divider (one above the 32-bit range)
   localparam int QUO_BITS = OUT_BITS + 1;

   localparam int N_ENTRY = 9;
   localparam int N_PROD  = 2 * N_ENTRY;

   // cofactor k = m[CF_A[2k]]*m[CF_B[2k]] - m[CF_A[2k+1]]*m[CF_B[2k+1]]
   // (already transposed: cofactor k is the numerator of inverse entry k)
   localparam logic [3:0] CF_A [0:N_PROD-1] = '{
      4'd4, 4'd5,  4'd2, 4'd1,  4'd1, 4'd2,
      4'd5, 4'd3,  4'd0, 4'd2,  4'd2, 4'd0,
      4'd3, 4'd4,  4'd1, 4'd0,  4'd0, 4'd1
   };
   localparam logic [3:0] CF_B [0:N_PROD-1] = '{
      4'd8, 4'd7,  4'd7, 4'd8,  4'd5, 4'd4,
      4'd6, 4'd8,  4'd8, 4'd6,  4'd3, 4'd5,
      4'd7, 4'd6,  4'd6, 4'd7,  4'd4, 4'd3
   };

   // clamp magnitudes
   localparam logic [QUO_BITS-1:0] LIM_POS = QUO_BITS'(32'h7FFF_FFFF);
   localparam logic [QUO_BITS-1:0] LIM_NEG = QUO_BITS'(32'h8000_0000);

endpackage

`default_nettype wire

>>> hdl/mi3_if.sv
// ============================================================================
// mi3_if
// Valid/ready channels of the 3x3 inverse unit: matrix in, inverse out.
// ============================================================================
`default_nettype none

interface mi3_req_if #(
   parameter int ENTRY_BITS = mi3_pkg::ENTRY_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [ENTRY_BITS-1:0] m00, m01, m02;
   logic signed [ENTRY_BITS-1:0] m10, m11, m12;
   logic signed [ENTRY_BITS-1:0] m20, m21, m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   output ready);
endinterface

interface mi3_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [mi3_pkg::OUT_BITS-1:0]  inv00, inv01, inv02;
   logic signed [mi3_pkg::OUT_BITS-1:0]  inv10, inv11, inv12;
   logic signed [mi3_pkg::OUT_BITS-1:0]  inv20, inv21, inv22;
   logic                                 singular;
   logic                                 saturated;

   modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                   inv20, inv21, inv22, singular, saturated, input ready);
   modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                   inv20, inv21, inv22, singular, saturated, output ready);
endinterface

`default_nettype wire

>>> hdl/matrix_inverse_3x3_unit.sv
// ============================================================================
// matrix_inverse_3x3_unit
// 3x3 fixed-point matrix inverse by the adjugate, fully pipelined.
// ============================================================================
// Takes one matrix per cycle and returns one inverse per cycle while the skid
// register is empty and rsp is ready. Stages: entry products, cofactors,
// determinant products, determinant sum, magnitudes, divider setup, then
// nine parallel restoring dividers that resolve one quotient bit per stage
// over 33 stages, the clamp/sign stage feeding the output register. The whole
// pipeline advances together; a skid register behind the output register
// takes a result arriving while rsp stalls; req ready is low while it is full.
`default_nettype none

module matrix_inverse_3x3_unit #(
   parameter int ENTRY_BITS = mi3_pkg::ENTRY_BITS_DEF,
   parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
   input  wire           clock,
   input  wire           reset,
   mi3_req_if.sink       req_chan,
   mi3_rsp_if.source     rsp_chan
);

   localparam int NE  = mi3_pkg::N_ENTRY;
   localparam int NP  = mi3_pkg::N_PROD;
   localparam int QB  = mi3_pkg::QUO_BITS;
   localparam int OB  = mi3_pkg::OUT_BITS;
   localparam int EB  = ENTRY_BITS;
   localparam int PW  = 2 * EB;                     // entry product
   localparam int CW  = PW + 1;                     // cofactor
   localparam int DPW = EB + CW;                    // determinant term
   localparam int DW  = DPW + 2;                    // determinant
   localparam int NSH = FRAC_BITS + mi3_pkg::OUT_FRAC;
   localparam int NW  = CW + NSH;                   // scaled numerator
   localparam int CPW = (NW > DW) ? NW : DW;        // setup compare width

   // pipeline advance: held only while the skid register is occupied
   logic en;
   logic skid_vld_ff;
   assign en = !skid_vld_ff;
   assign req_chan.ready = en;

   // --------------------------------------------------------------- stage 1
   // entry products
   logic signed [EB-1:0] mi [0:NE-1];
   assign mi[0] = req_chan.m00;  assign mi[1] = req_chan.m01;
   assign mi[2] = req_chan.m02;  assign mi[3] = req_chan.m10;
   assign mi[4] = req_chan.m11;  assign mi[5] = req_chan.m12;
   assign mi[6] = req_chan.m20;  assign mi[7] = req_chan.m21;
   assign mi[8] = req_chan.m22;

   logic signed [PW-1:0] p_in  [0:NP-1];
   logic signed [PW-1:0] p_ff  [0:NP-1];
   logic signed [EB-1:0] r1_ff [0:2];
   logic                 v1_ff;

   always_comb begin
      for (int k = 0; k < NP; k++) begin
         p_in[k] = mi[mi3_pkg::CF_A[k]] * mi[mi3_pkg::CF_B[k]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
      end
      if (en) begin
         p_ff  <= p_in;
         r1_ff <= mi[0:2];
      end
   end

   // --------------------------------------------------------------- stage 2
   // cofactors (already transposed into adjugate order)
   logic signed [CW-1:0] c2_in [0:NE-1];
   logic signed [CW-1:0] c2_ff [0:NE-1];
   logic signed [EB-1:0] r2_ff [0:2];
   logic                 v2_ff;

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         c2_in[k] = CW'(p_ff[2*k]) - CW'(p_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         c2_ff <= c2_in;
         r2_ff <= r1_ff;
      end
   end

   // --------------------------------------------------------------- stage 3
   // determinant terms: first row times first adjugate column
   logic signed [DPW-1:0] dp_in [0:2];
   logic signed [DPW-1:0] dp_ff [0:2];
   logic signed [CW-1:0]  c3_ff [0:NE-1];
   logic                  v3_ff;

   assign dp_in[0] = r2_ff[0] * c2_ff[0];
   assign dp_in[1] = r2_ff[1] * c2_ff[3];
   assign dp_in[2] = r2_ff[2] * c2_ff[6];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         dp_ff <= dp_in;
         c3_ff <= c2_ff;
      end
   end

   // --------------------------------------------------------------- stage 4
   // determinant sum
   logic signed [DW-1:0] d_in;
   logic signed [DW-1:0] d_ff;
   logic signed [CW-1:0] c4_ff [0:NE-1];
   logic                 v4_ff;

   assign d_in = DW'(dp_ff[0]) + DW'(dp_ff[1]) + DW'(dp_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         d_ff  <= d_in;
         c4_ff <= c3_ff;
      end
   end

   // --------------------------------------------------------------- stage 5
   // magnitudes and result signs
   logic [DW-1:0] dm5_in;
   logic [DW-1:0] dm5_ff;
   logic [CW-1:0] cm5_in  [0:NE-1];
   logic [CW-1:0] cm5_ff  [0:NE-1];
   logic [NE-1:0] neg5_in;
   logic [NE-1:0] neg5_ff;
   logic          sing5_ff;
   logic          v5_ff;

   always_comb begin
      dm5_in = d_ff[DW-1] ? (~d_ff + 1'b1) : d_ff;
      for (int k = 0; k < NE; k++) begin
         cm5_in[k]  = c4_ff[k][CW-1] ? (~c4_ff[k] + 1'b1) : c4_ff[k];
         neg5_in[k] = c4_ff[k][CW-1] ^ d_ff[DW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         dm5_ff   <= dm5_in;
         cm5_ff   <= cm5_in;
         neg5_ff  <= neg5_in;
         sing5_ff <= (d_ff == '0);
      end
   end

   // ------------------------------------------------------- divider arrays
   // index 0 is the setup stage, index QB holds the finished quotients
   logic [DW-1:0] dv_r_ff   [0:QB][0:NE-1];
   logic [QB-1:0] dv_q_ff   [0:QB][0:NE-1];
   logic [QB-1:0] dv_lo_ff  [0:QB][0:NE-1];
   logic [DW-1:0] dv_dm_ff  [0:QB];
   logic [NE-1:0] dv_neg_ff [0:QB];
   logic [NE-1:0] dv_ovf_ff [0:QB];
   logic          dv_sing_ff[0:QB];
   logic          dv_vld_ff [0:QB];

   // --------------------------------------------------------------- stage 6
   // divider setup: quotients of 2^33 or more saturate, the rest start
   // with the numerator bits above the quotient window as remainder
   logic [NW-1:0]  num6   [0:NE-1];
   logic [CPW-1:0] hi6    [0:NE-1];
   logic [DW-1:0]  r6_in  [0:NE-1];
   logic [QB-1:0]  lo6_in [0:NE-1];
   logic [NE-1:0]  ovf6_in;

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         num6[k]    = {cm5_ff[k], {NSH{1'b0}}};
         hi6[k]     = CPW'(num6[k] >> QB);
         lo6_in[k]  = num6[k][QB-1:0];
         r6_in[k]   = hi6[k][DW-1:0];
         ovf6_in[k] = (hi6[k] >= CPW'(dm5_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (en) begin
         dv_vld_ff[0] <= v5_ff;
      end
      if (en) begin
         dv_r_ff[0]    <= r6_in;
         dv_lo_ff[0]   <= lo6_in;
         dv_dm_ff[0]   <= dm5_ff;
         dv_neg_ff[0]  <= neg5_ff;
         dv_ovf_ff[0]  <= ovf6_in;
         dv_sing_ff[0] <= sing5_ff;
         for (int k = 0; k < NE; k++) begin
            dv_q_ff[0][k] <= '0;
         end
      end
   end

   // ------------------------------------------------------ divider stages
   // one restoring step per stage and lane
   for (genvar j = 0; j < QB; j++) begin : g_div
      logic [DW:0]   r2   [0:NE-1];
      logic [DW-1:0] r_in [0:NE-1];
      logic [QB-1:0] q_in [0:NE-1];
      logic [DW:0]   den;

      assign den = {1'b0, dv_dm_ff[j]};

      always_comb begin
         for (int k = 0; k < NE; k++) begin
            r2[k]   = {dv_r_ff[j][k], dv_lo_ff[j][k][QB-1-j]};
            q_in[k] = dv_q_ff[j][k];
            if (r2[k] >= den) begin
               r_in[k]        = DW'(r2[k] - den);
               q_in[k][QB-1-j] = 1'b1;
            end else begin
               r_in[k] = r2[k][DW-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j+1] <= 1'b0;
         end else if (en) begin
            dv_vld_ff[j+1] <= dv_vld_ff[j];
         end
         if (en) begin
            dv_r_ff[j+1]    <= r_in;
            dv_q_ff[j+1]    <= q_in;
            dv_lo_ff[j+1]   <= dv_lo_ff[j];
            dv_dm_ff[j+1]   <= dv_dm_ff[j];
            dv_neg_ff[j+1]  <= dv_neg_ff[j];
            dv_ovf_ff[j+1]  <= dv_ovf_ff[j];
            dv_sing_ff[j+1] <= dv_sing_ff[j];
         end
      end
   end

   // ------------------------------------------------------- clamp and sign
   logic [QB-1:0] lim   [0:NE-1];
   logic [QB-1:0] mag   [0:NE-1];
   logic [NE-1:0] clip;
   logic [OB-1:0] res_in [0:NE-1];
   logic          sing_in;
   logic          sat_in;

   always_comb begin
      sing_in = dv_sing_ff[QB];
      for (int k = 0; k < NE; k++) begin
         lim[k]  = dv_neg_ff[QB][k] ? mi3_pkg::LIM_NEG : mi3_pkg::LIM_POS;
         clip[k] = dv_ovf_ff[QB][k] || (dv_q_ff[QB][k] > lim[k]);
         mag[k]  = clip[k] ? lim[k] : dv_q_ff[QB][k];
         if (sing_in) begin
            res_in[k] = '0;
         end else if (dv_neg_ff[QB][k]) begin
            res_in[k] = ~mag[k][OB-1:0] + 1'b1;
         end else begin
            res_in[k] = mag[k][OB-1:0];
         end
      end
      sat_in = !sing_in && (clip != '0);
   end

   // ------------------------------------------------- output and skid regs
   logic          out_vld_ff;
   logic [OB-1:0] out_res_ff  [0:NE-1];
   logic          out_sing_ff;
   logic          out_sat_ff;
   logic [OB-1:0] skid_res_ff [0:NE-1];
   logic          skid_sing_ff;
   logic          skid_sat_ff;
   logic          take;

   assign take = out_vld_ff && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         // pipeline held; drain the skid entry on a transfer
         if (take) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (!out_vld_ff || take) begin
         out_vld_ff <= dv_vld_ff[QB];
      end else if (dv_vld_ff[QB]) begin
         skid_vld_ff <= 1'b1;
      end

      if (skid_vld_ff) begin
         if (take) begin
            out_res_ff  <= skid_res_ff;
            out_sing_ff <= skid_sing_ff;
            out_sat_ff  <= skid_sat_ff;
         end
      end else if (!out_vld_ff || take) begin
         out_res_ff  <= res_in;
         out_sing_ff <= sing_in;
         out_sat_ff  <= sat_in;
      end else begin
         skid_res_ff  <= res_in;
         skid_sing_ff <= sing_in;
         skid_sat_ff  <= sat_in;
      end
   end

   assign rsp_chan.valid     = out_vld_ff;
   assign rsp_chan.inv00     = out_res_ff[0];
   assign rsp_chan.inv01     = out_res_ff[1];
   assign rsp_chan.inv02     = out_res_ff[2];
   assign rsp_chan.inv10     = out_res_ff[3];
   assign rsp_chan.inv11     = out_res_ff[4];
   assign rsp_chan.inv12     = out_res_ff[5];
   assign rsp_chan.inv20     = out_res_ff[6];
   assign rsp_chan.inv21     = out_res_ff[7];
   assign rsp_chan.inv22     = out_res_ff[8];
   assign rsp_chan.singular  = out_sing_ff;
   assign rsp_chan.saturated = out_sat_ff;

endmodule

`default_nettype wire

>>> hdl/mi3_checker.sv
// ============================================================================
// mi3_checker
// Port-level checks on the result channel of the 3x3 inverse unit.
// ============================================================================
`default_nettype none

`include "matrix_inverse_3x3_unit_assert.svh"

module mi3_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input wire [mi3_pkg::OUT_BITS-1:0] rsp_inv00,
   input wire [mi3_pkg::OUT_BITS-1:0] rsp_inv01,
   input wire [mi3_pkg::OUT_BITS-1:0] rsp_inv02,
   input wire [mi3_pkg::OUT_BITS-1:0] rsp_inv10,
   input wire [mi3_pkg::OUT_BITS-1:0] rsp_inv11,
   input wire [mi3_pkg::OUT_BITS-1:0] rsp_inv12,
   input wire [mi3_pkg::OUT_BITS-1:0] rsp_inv20,
   input wire [mi3_pkg::OUT_BITS-1:0] rsp_inv21,
   input wire [mi3_pkg::OUT_BITS-1:0] rsp_inv22,
   input wire                         rsp_singular,
   input wire                         rsp_saturated
);

   // singular result carries an all-zero inverse
   `MI3_ASSERT(a_sing_zero, clock, reset, rsp_valid && rsp_singular |-> (rsp_inv00 == '0 && rsp_inv01 == '0 && rsp_inv02 == '0 && rsp_inv10 == '0 && rsp_inv11 == '0 && rsp_inv12 == '0 && rsp_inv20 == '0 && rsp_inv21 == '0 && rsp_inv22 == '0), "singular result with nonzero entries")

   // singular and saturated never come together
   `MI3_ASSERT(a_sing_nosat, clock, reset, rsp_valid && rsp_singular |-> !rsp_saturated, "singular result flagged saturated")

   // a stalled result stays offered
   `MI3_ASSERT(a_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // reset empties the output
   `MI3_ASSERT_NR(a_reset, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind matrix_inverse_3x3_unit mi3_checker u_mi3_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_inv00     (rsp_chan.inv00),
   .rsp_inv01     (rsp_chan.inv01),
   .rsp_inv02     (rsp_chan.inv02),
   .rsp_inv10     (rsp_chan.inv10),
   .rsp_inv11     (rsp_chan.inv11),
   .rsp_inv12     (rsp_chan.inv12),
   .rsp_inv20     (rsp_chan.inv20),
   .rsp_inv21     (rsp_chan.inv21),
   .rsp_inv22     (rsp_chan.inv22),
   .rsp_singular  (rsp_chan.singular),
   .rsp_saturated (rsp_chan.saturated)
);

`default_nettype wire

>>> tb/matrix_inverse_3x3_unit_checker.sv
// ============================================================================
// matrix_inverse_3x3_unit_checker
// Watches both channels, predicts each inverse and compares it with the output.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module matrix_inverse_3x3_unit_checker (
   input  wire  clock,
   input  wire  reset,
   mi3_req_if   req_chan,
   mi3_rsp_if   rsp_chan,
   output int   fail_count,
   output int   pending_count,
   output int   singular_seen,
   output int   saturated_seen
);

   typedef struct {
      logic signed [31:0] inv [9];
      logic               singular;
      logic               saturated;
   } inverse_type;

   inverse_type inverse_q [$];

   // Exact adjugate inverse with truncation toward zero and 32-bit clamp
   function automatic inverse_type compute_inverse(input logic signed [15:0] m [9]);
      inverse_type      r;
      longint           c [9];
      logic signed [127:0] det, num, dm, q, cm;
      logic             neg;
      logic [127:0]     lim;
      c[0] = m[4] * m[8] - m[5] * m[7];
      c[1] = m[2] * m[7] - m[1] * m[8];
      c[2] = m[1] * m[5] - m[2] * m[4];
      c[3] = m[5] * m[6] - m[3] * m[8];
      c[4] = m[0] * m[8] - m[2] * m[6];
      c[5] = m[2] * m[3] - m[0] * m[5];
      c[6] = m[3] * m[7] - m[4] * m[6];
      c[7] = m[1] * m[6] - m[0] * m[7];
      c[8] = m[0] * m[4] - m[1] * m[3];
      det = 128'(m[0]) * 128'(c[0]) + 128'(m[1]) * 128'(c[3])
          + 128'(m[2]) * 128'(c[6]);
      r.singular  = (det == 0);
      r.saturated = 1'b0;
      dm = (det < 0) ? -det : det;
      for (int i = 0; i < 9; i++) begin
         r.inv[i] = '0;
         if (!r.singular) begin
            cm  = (c[i] < 0) ? -128'(c[i]) : 128'(c[i]);
            neg = (c[i] < 0) != (det < 0);
            num = cm <<< 24;
            q   = num / dm;
            lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (q > lim) begin
               q = lim;
               r.saturated = 1'b1;
            end
            r.inv[i] = neg ? -q[31:0] : q[31:0];
         end
      end
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      singular_seen = 0;
      saturated_seen = 0;
   end

   // Predict on each input transfer, check on each output transfer
   always @(posedge clock) begin
      logic signed [15:0] m [9];
      inverse_type        e;
      logic signed [31:0] a [9];
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            m = '{req_chan.m00, req_chan.m01, req_chan.m02, req_chan.m10,
                  req_chan.m11, req_chan.m12, req_chan.m20, req_chan.m21,
                  req_chan.m22};
            inverse_q.push_back(compute_inverse(m));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            a = '{rsp_chan.inv00, rsp_chan.inv01, rsp_chan.inv02, rsp_chan.inv10,
                  rsp_chan.inv11, rsp_chan.inv12, rsp_chan.inv20, rsp_chan.inv21,
                  rsp_chan.inv22};
            if (inverse_q.size() == 0) begin
               $error("inverse transfer with no matrix outstanding");
               fail_count++;
            end else begin
               e = inverse_q.pop_front();
               singular_seen  += e.singular;
               saturated_seen += e.saturated;
               for (int i = 0; i < 9; i++)
                  compare_field($sformatf("inv%0d%0d", i / 3, i % 3), e.inv[i], a[i]);
               compare_field("singular", e.singular, rsp_chan.singular);
               compare_field("saturated", e.saturated, rsp_chan.saturated);
            end
         end
         pending_count = inverse_q.size();
      end
   end

endmodule

`default_nettype wire

>>> tb/matrix_inverse_3x3_unit_test.sv
// ============================================================================
// matrix_inverse_3x3_unit_test
// Directed and random matrices through the inverse unit with random stalls.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module matrix_inverse_3x3_unit_test;

   localparam int RANDOM_ITEMS = 1830;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, singular_seen, saturated_seen;
   int   cycle_count = 0;
   int   sent_count = 0;
   bit   quiet_phase = 0;
   bit   hold_off = 0;

   mi3_req_if req_chan ();
   mi3_rsp_if rsp_chan ();

   matrix_inverse_3x3_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   matrix_inverse_3x3_unit_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .singular_seen  (singular_seen),
      .saturated_seen (saturated_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** matrix_inverse_3x3_unit: FAILED **");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         rsp_chan.ready <= quiet_phase || ($urandom_range(99) >= 10);
         @(posedge clock);
      end
   end

   logic signed [15:0] mat [9];

   // Offer one matrix and hold it until it is transferred
   task automatic send_matrix(input logic signed [15:0] v [9]);
      while (!quiet_phase && $urandom_range(99) < 10) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      {req_chan.m00, req_chan.m01, req_chan.m02, req_chan.m10, req_chan.m11,
       req_chan.m12, req_chan.m20, req_chan.m21, req_chan.m22} <=
         {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   function automatic logic signed [15:0] rand_entry(input int style);
      case (style)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(1024)) - 512);
         2: return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
         default: return 16'($urandom_range(3)) - 16'sd1;
      endcase
   endfunction

   initial begin
      int style;
      req_chan.valid = 1'b0;
      {req_chan.m00, req_chan.m01, req_chan.m02, req_chan.m10, req_chan.m11,
       req_chan.m12, req_chan.m20, req_chan.m21, req_chan.m22} = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity, zero, extremes, singular, tiny determinant, negatives
      send_matrix('{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100});
      send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
      send_matrix('{-1, 0, 0, 0, 1, 0, 0, 0, 1});
      send_matrix('{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF});
      send_matrix('{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000});
      send_matrix('{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                    16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF});
      send_matrix('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
      send_matrix('{16'sh0100, 16'sh0200, 16'sh0300, 16'sh0200, 16'sh0400,
                    16'sh0600, 16'sh0100, 0, 16'sh0100});
      send_matrix('{0, 16'sh0100, 0, 16'sh0100, 0, 0, 0, 0, 16'sh0100});
      send_matrix('{16'sh0200, 0, 0, 0, 16'sh0200, 0, 0, 0, 16'sh0200});
      send_matrix('{16'sh8000, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100});
      send_matrix('{16'sh7FFF, 16'sh7FFF, 0, 16'sh7FFF, 16'sh7FFE, 0,
                    0, 0, 1});

      // Long hold-off with the sender running flat out
      quiet_phase = 1;
      hold_off = 1;
      for (int i = 0; i < 80; i++) begin
         foreach (mat[k]) mat[k] = rand_entry(1);
         send_matrix(mat);
      end
      quiet_phase = 0;

      // Random matrices; some with a duplicated row to force singular results
      for (int i = 0; i < RANDOM_ITEMS - 80; i++) begin
         if (i > 700 && i < 900) quiet_phase = 1;
         else quiet_phase = 0;
         style = $urandom_range(3);
         foreach (mat[k]) mat[k] = rand_entry(style);
         if ($urandom_range(9) == 0)
            for (int k = 0; k < 3; k++) mat[6 + k] = mat[k];
         send_matrix(mat);
      end
      req_chan.valid <= 1'b0;
      quiet_phase = 0;

      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Sent %0d matrices: %0d singular, %0d clamped, with random stalls",
               sent_count, singular_seen, saturated_seen);
      if (fail_count == 0)
         $display("** matrix_inverse_3x3_unit: PASSED **");
      else
         $display("** matrix_inverse_3x3_unit: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
